// ----- src/mtrp_pkg.sv -----
package mtrp_pkg;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_ADDR   = 2'd1,
    PH_COUNT  = 2'd2,
    PH_HITS   = 2'd3
  } phase_e;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned AddrW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned HitsW  = 32;
  localparam int unsigned IdxW   = 3;

  // header field positions
  localparam int unsigned HdrWriteBit = 7;
  localparam int unsigned HdrAddrLsb  = 4;
  localparam int unsigned HdrCountLsb = 2;
  localparam int unsigned HdrHitsLsb  = 0;

  typedef struct packed {
    logic              is_write;
    logic [AddrW-1:0]  address;
    logic [CountW-1:0] instruction_count;
    logic [HitsW-1:0]  hit_count;
  } record_t;

  typedef struct packed {
    phase_e phase;
    logic   last;
  } dec_status_t;

endpackage

// ----- src/mtrp_in_stage.sv -----
module mtrp_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [mtrp_pkg::ByteW-1:0] data_byte_i,
  output logic                      byte_valid_o,
  input  logic                      byte_take_i,
  output logic [mtrp_pkg::ByteW-1:0] byte_o
);

  logic                       valid_q, valid_d;
  logic [mtrp_pkg::ByteW-1:0] byte_q;

  // the register frees up in the same cycle its word is consumed
  assign in_ready_o = !valid_q || byte_take_i;
  assign valid_d    = (in_valid_i && in_ready_o) || (valid_q && !byte_take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  assign byte_valid_o = valid_q;
  assign byte_o       = byte_q;

endmodule

// ----- src/mtrp_decode.sv -----
module mtrp_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [mtrp_pkg::ByteW-1:0]  byte_i,
  output mtrp_pkg::record_t           rec_o,
  output mtrp_pkg::dec_status_t       status_o
);

  mtrp_pkg::phase_e                  phase_q, phase_d;
  logic [mtrp_pkg::IdxW-1:0]         idx_q, idx_d;
  logic [2:0]                        addr_len_q, addr_len_d;
  logic [1:0]                        cnt_len_q, cnt_len_d;
  logic [1:0]                        hit_len_q, hit_len_d;
  logic                              wr_q, wr_d;
  logic [mtrp_pkg::AddrW-1:0]        addr_q, addr_d;
  logic [mtrp_pkg::CountW-1:0]       cnt_q, cnt_d;
  logic [mtrp_pkg::HitsW-1:0]        hit_q, hit_d;
  logic                              last;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    addr_len_d = addr_len_q;
    cnt_len_d  = cnt_len_q;
    hit_len_d  = hit_len_q;
    wr_d       = wr_q;
    addr_d     = addr_q;
    cnt_d      = cnt_q;
    hit_d      = hit_q;
    last       = 1'b0;
    unique case (phase_q)
      mtrp_pkg::PH_HEADER: begin
        wr_d       = byte_i[mtrp_pkg::HdrWriteBit];
        addr_len_d = byte_i[mtrp_pkg::HdrAddrLsb +: 3];
        cnt_len_d  = byte_i[mtrp_pkg::HdrCountLsb +: 2];
        hit_len_d  = byte_i[mtrp_pkg::HdrHitsLsb +: 2];
        addr_d     = '0;
        cnt_d      = '0;
        hit_d      = '0;
        idx_d      = '0;
        phase_d    = mtrp_pkg::PH_ADDR;
      end
      mtrp_pkg::PH_ADDR: begin
        addr_d = addr_q | ({{(mtrp_pkg::AddrW-mtrp_pkg::ByteW){1'b0}}, byte_i}
                           << {idx_q, 3'b000});
        if (idx_q == addr_len_q) begin
          idx_d   = '0;
          phase_d = mtrp_pkg::PH_COUNT;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      mtrp_pkg::PH_COUNT: begin
        cnt_d = cnt_q | ({{(mtrp_pkg::CountW-mtrp_pkg::ByteW){1'b0}}, byte_i}
                         << {idx_q[1:0], 3'b000});
        if (idx_q >= {1'b0, cnt_len_q}) begin
          idx_d   = '0;
          phase_d = mtrp_pkg::PH_HITS;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      mtrp_pkg::PH_HITS: begin
        hit_d = hit_q | ({{(mtrp_pkg::HitsW-mtrp_pkg::ByteW){1'b0}}, byte_i}
                         << {idx_q[1:0], 3'b000});
        if (idx_q >= {1'b0, hit_len_q}) begin
          idx_d   = '0;
          phase_d = mtrp_pkg::PH_HEADER;
          last    = 1'b1;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
      default: phase_d = mtrp_pkg::PH_HEADER;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mtrp_pkg::PH_HEADER;
      idx_q      <= '0;
      addr_len_q <= '0;
      cnt_len_q  <= '0;
      hit_len_q  <= '0;
      wr_q       <= 1'b0;
      addr_q     <= '0;
      cnt_q      <= '0;
      hit_q      <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      idx_q      <= idx_d;
      addr_len_q <= addr_len_d;
      cnt_len_q  <= cnt_len_d;
      hit_len_q  <= hit_len_d;
      wr_q       <= wr_d;
      addr_q     <= addr_d;
      cnt_q      <= cnt_d;
      hit_q      <= hit_d;
    end
  end

  // finished record, valid together with status_o.last
  assign rec_o.is_write          = wr_q;
  assign rec_o.address           = addr_q;
  assign rec_o.instruction_count = cnt_q;
  assign rec_o.hit_count         = hit_d;

  assign status_o.phase = phase_q;
  assign status_o.last  = last;

endmodule

// ----- src/mtrp_out_stage.sv -----
module mtrp_out_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mtrp_pkg::record_t rec_i,
  output logic              can_take_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mtrp_pkg::record_t rec_o
);

  logic              valid_q, valid_d;
  mtrp_pkg::record_t rec_q;

  assign can_take_o = !valid_q || out_ready_i;
  assign valid_d    = load_i || (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

  assign out_valid_o = valid_q;
  assign rec_o       = rec_q;

endmodule

// ----- src/memory_trace_record_parser.sv -----
// memory trace record parser
// input channel: one stream word per handshake on data_byte_i (in_valid_i /
//   in_ready_o); a record is a header word followed by 1-8 address words,
//   1-4 instruction-count words and 1-4 hit-count words, all little-endian
// output channel: one decoded record per handshake (out_valid_o / out_ready_i)
//   on is_write_o, address_o, instruction_count_o and hit_count_o
// throughput: one word per cycle unless a waiting record stalls the input;
//   header and field words are all decoded by a single byte insert between
//   the input register and the result register
// path: the last hit-count word is held in the input register, then the
//   finished record is loaded into the result register behind out_valid_o
// stall: a waiting record holds in the result register; the input register
//   still takes one more word, and in_ready_o drops only when both are full
// reset: rst_ni clears both registers and returns the parser to expecting a
//   header word; a partly received record is dropped
module memory_trace_record_parser (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [mtrp_pkg::ByteW-1:0]   data_byte_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         is_write_o,
  output logic [mtrp_pkg::AddrW-1:0]   address_o,
  output logic [mtrp_pkg::CountW-1:0]  instruction_count_o,
  output logic [mtrp_pkg::HitsW-1:0]   hit_count_o
);

  logic                       byte_valid;
  logic [mtrp_pkg::ByteW-1:0] byte_w;
  logic                       can_take;
  logic                       fire;
  mtrp_pkg::record_t          rec_dec, rec_out;
  mtrp_pkg::dec_status_t      status;

  assign fire = byte_valid && can_take;

  mtrp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .byte_valid_o (byte_valid),
    .byte_take_i  (fire),
    .byte_o       (byte_w)
  );

  mtrp_decode u_dec (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .byte_i   (byte_w),
    .rec_o    (rec_dec),
    .status_o (status)
  );

  mtrp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire && status.last),
    .rec_i       (rec_dec),
    .can_take_o  (can_take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .rec_o       (rec_out)
  );

  assign is_write_o          = rec_out.is_write;
  assign address_o           = rec_out.address;
  assign instruction_count_o = rec_out.instruction_count;
  assign hit_count_o         = rec_out.hit_count;

  // ready drops only when both registers are full and the receiver stalls
  a_ready_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (byte_valid && out_valid_o && !out_ready_i))
    else $error("input stalled without a full pipeline");

  // a record is completed only in the hit-count phase
  a_last_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.last |-> (status.phase == mtrp_pkg::PH_HITS))
    else $error("record completed outside hit-count phase");

  // a completed record always returns the parser to the header phase
  a_back_to_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && status.last) |=> (status.phase == mtrp_pkg::PH_HEADER))
    else $error("parser did not return to header phase");

  // the header word never yields a record and always starts the address phase
  a_header_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && status.phase == mtrp_pkg::PH_HEADER) |=>
      (status.phase == mtrp_pkg::PH_ADDR && !$rose(out_valid_o)))
    else $error("header word handled wrongly");

endmodule

// ----- verif/testbench.sv -----
module testbench;
  import mtrp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned StreamBytes = 525;
  localparam int unsigned ReportMax   = 10;

  // tracks the record framing and predicts every decoded record
  class record_scoreboard;
    phase_e            phase;
    logic [IdxW-1:0]   idx;
    logic [2:0]        addr_last;
    logic [1:0]        count_last;
    logic [1:0]        hits_last;
    logic              wr_flag;
    logic [AddrW-1:0]  addr_acc;
    logic [CountW-1:0] count_acc;
    logic [HitsW-1:0]  hits_acc;
    record_t           pending_q[$];
    int unsigned       mismatches;

    function new();
      phase      = PH_HEADER;
      idx        = '0;
      addr_last  = '0;
      count_last = '0;
      hits_last  = '0;
      wr_flag    = 1'b0;
      addr_acc   = '0;
      count_acc  = '0;
      hits_acc   = '0;
      mismatches = 0;
    endfunction

    function void note_word(logic [ByteW-1:0] w);
      record_t rec;
      case (phase)
        PH_HEADER: begin
          wr_flag    = w[HdrWriteBit];
          addr_last  = w[HdrAddrLsb +: 3];
          count_last = w[HdrCountLsb +: 2];
          hits_last  = w[HdrHitsLsb +: 2];
          addr_acc   = '0;
          count_acc  = '0;
          hits_acc   = '0;
          idx        = '0;
          phase      = PH_ADDR;
        end
        PH_ADDR: begin
          addr_acc = addr_acc | (AddrW'(w) << (idx * 8));
          if (idx == addr_last) begin
            idx   = '0;
            phase = PH_COUNT;
          end else begin
            idx = idx + 1'b1;
          end
        end
        PH_COUNT: begin
          count_acc = count_acc | (CountW'(w) << (idx[1:0] * 8));
          if (idx >= IdxW'(count_last)) begin
            idx   = '0;
            phase = PH_HITS;
          end else begin
            idx = idx + 1'b1;
          end
        end
        default: begin
          hits_acc = hits_acc | (HitsW'(w) << (idx[1:0] * 8));
          if (idx >= IdxW'(hits_last)) begin
            idx                   = '0;
            phase                 = PH_HEADER;
            rec.is_write          = wr_flag;
            rec.address           = addr_acc;
            rec.instruction_count = count_acc;
            rec.hit_count         = hits_acc;
            pending_q.push_back(rec);
          end else begin
            idx = idx + 1'b1;
          end
        end
      endcase
    endfunction

    function void check_record(record_t got);
      record_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected record: wr %0b addr %h icount %h hits %h",
                   got.is_write, got.address, got.instruction_count, got.hit_count);
        return;
      end
      want = pending_q.pop_front();
      if (got.is_write !== want.is_write || got.address !== want.address ||
          got.instruction_count !== want.instruction_count ||
          got.hit_count !== want.hit_count) begin
        mismatches++;
        if (mismatches <= ReportMax) begin
          $display("record mismatch: expected wr %0b addr %h icount %h hits %h",
                   want.is_write, want.address, want.instruction_count, want.hit_count);
          $display("                 actual   wr %0b addr %h icount %h hits %h",
                   got.is_write, got.address, got.instruction_count, got.hit_count);
        end
      end
    endfunction
  endclass

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [ByteW-1:0]   data_byte_i = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               is_write_o;
  logic [AddrW-1:0]   address_o;
  logic [CountW-1:0]  instruction_count_o;
  logic [HitsW-1:0]   hit_count_o;

  record_scoreboard   sb = new();
  logic [ByteW-1:0]   stream_q[$];
  int unsigned        cycle_count = 0;
  bit                 calm = 1'b0;

  memory_trace_record_parser dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .data_byte_i         (data_byte_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .is_write_o          (is_write_o),
    .address_o           (address_o),
    .instruction_count_o (instruction_count_o),
    .hit_count_o         (hit_count_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // check before noting so a result never pairs with a word of the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_record({is_write_o, address_o, instruction_count_o, hit_count_o});
      if (in_valid_i && in_ready_o)
        sb.note_word(data_byte_i);
    end
  end

  function automatic int unsigned draw_gap();
    if (calm) return 0;
    return $urandom_range(0, 8);
  endfunction

  function automatic logic [ByteW-1:0] field_word();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hff;
      default: return ByteW'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_stream();
    logic [ByteW-1:0] hdr;
    int unsigned      n;
    // all-zero record, all-ones record with widest fields, write record with one-word fields
    stream_q = '{8'h00, 8'h00, 8'h00, 8'h00};
    stream_q.push_back(8'hff);
    repeat (16) stream_q.push_back(8'hff);
    stream_q.push_back(8'h80);
    stream_q.push_back(8'h5a);
    stream_q.push_back(8'ha5);
    stream_q.push_back(8'h3c);
    while (stream_q.size() < StreamBytes) begin
      hdr = ByteW'($urandom_range(0, 255));
      stream_q.push_back(hdr);
      n = hdr[HdrAddrLsb +: 3] + hdr[HdrCountLsb +: 2] + hdr[HdrHitsLsb +: 2] + 3;
      repeat (n) stream_q.push_back(field_word());
    end
  endtask

  task automatic send_word(logic [ByteW-1:0] w);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= w;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_records();
    int unsigned gap;
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  endtask

  initial begin
    build_stream();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      drain_records();
    join_none
    foreach (stream_q[i]) send_word(stream_q[i]);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
